@@ src/icdf_pkg.sv @@
`default_nettype none

package icdf_pkg;

   // field widths
   localparam int OPCODE_W   = 1;
   localparam int INDEX_W    = 10;
   localparam int CUM_W      = 32;
   localparam int ENERGY_W   = 24;
   localparam int POINTS_W   = 11;
   localparam int PROD_W     = CUM_W + ENERGY_W;

   // stream payload widths, padded to whole bytes
   localparam int REQ_FIELDS_W = INDEX_W + CUM_W + ENERGY_W + CUM_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ENERGY_W + INDEX_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // table sizing
   localparam int MAX_POINTS_DEFAULT = 1024;
   localparam int MIN_POINTS         = 65;
   localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(1024);

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD   = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

endpackage

`default_nettype wire

@@ src/inverse_cdf_table_sampler.sv @@
`default_nettype none

// load item: written into both tables at the transfer; loads can follow back to back
// sample item: binary search over the n entries in use, an address and a compare state per
//   halving step through the table's registered read port, then bracket reads, multiply and a
//   24-bit one-bit-a-cycle division; no request is taken until the result is handed to the
//   output register; end entries and zero fractions skip the multiply and the division
// reset (synchronous): controller idle, no result pending, points_in_use = 1024, tables kept
module inverse_cdf_table_sampler #(
   parameter int MAX_POINTS = icdf_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: entry_index, cumulative_value, energy_value, uniform_value, zero pad
   input  wire logic [icdf_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode
   input  wire logic [icdf_pkg::OPCODE_W-1:0]   req_tuser,

   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: sampled_energy, lower_entry, zero pad
   output logic      [icdf_pkg::RSP_DATA_W-1:0] rsp_tdata,

   // configuration: points_in_use
   input  wire logic                            csr_wr_en,
   input  wire logic [icdf_pkg::POINTS_W-1:0]   csr_wr_data
);

   import icdf_pkg::*;

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_ADDR,
      S_SRCH_CMP,
      S_RD_HI,
      S_RD_LO,
      S_LATCH_LO,
      S_EVAL,
      S_MUL,
      S_DIV_GO,
      S_DIV_WAIT,
      S_DONE
   } state_type;

   // request fields
   logic [INDEX_W-1:0]  req_entry_index;
   logic [CUM_W-1:0]    req_cumulative;
   logic [ENERGY_W-1:0] req_energy;
   logic [CUM_W-1:0]    req_uniform;

   assign req_entry_index = req_tdata[INDEX_W-1:0];
   assign req_cumulative  = req_tdata[INDEX_W+CUM_W-1:INDEX_W];
   assign req_energy      = req_tdata[INDEX_W+CUM_W+ENERGY_W-1:INDEX_W+CUM_W];
   assign req_uniform     = req_tdata[REQ_FIELDS_W-1:INDEX_W+CUM_W+ENERGY_W];

   // registers
   state_type           state_ff, state_in;
   logic [POINTS_W-1:0] points_ff, points_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CUM_W-1:0]    u_ff, u_in;
   logic [CNT_W-1:0]    first_ff, first_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   lo_ff, lo_in;
   logic                direct_ff, direct_in;
   logic [CUM_W-1:0]    c_hi_ff, c_hi_in;
   logic [ENERGY_W-1:0] e_hi_ff, e_hi_in;
   logic [CUM_W-1:0]    c_lo_ff, c_lo_in;
   logic [ENERGY_W-1:0] e_lo_ff, e_lo_in;
   logic [CUM_W-1:0]    span_ff, span_in;
   logic [CUM_W-1:0]    num_ff, num_in;
   logic [ENERGY_W-1:0] diff_ff, diff_in;
   logic                up_ff, up_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ENERGY_W-1:0] result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0] rsp_energy_ff, rsp_energy_in;
   logic [INDEX_W-1:0]  rsp_lower_ff, rsp_lower_in;

   // table ports
   logic                tbl_wr_en;
   logic [ADDR_W-1:0]   tbl_wr_addr;
   logic [ADDR_W-1:0]   tbl_rd_addr;
   logic [CUM_W-1:0]    cum_rd_data;
   logic [ENERGY_W-1:0] energy_rd_data;

   // divider
   logic                div_start;
   logic                div_done;
   logic [ENERGY_W-1:0] div_quotient;

   // search and evaluation helpers
   logic                req_xfer;
   logic [CNT_W-1:0]    step;
   logic [CNT_W-1:0]    mid;
   logic [CNT_W-1:0]    clamp_n;
   logic [CUM_W-1:0]    num_raw;

   assign req_xfer = req_tvalid & req_tready;

   // writes land at the transfer of a load item; indexes past the table are dropped
   assign tbl_wr_en   = req_xfer && (req_tuser == OP_LOAD) &&
                        ({22'b0, req_entry_index} < 32'(MAX_POINTS));
   assign tbl_wr_addr = ADDR_W'(req_entry_index);

   icdf_ram #(
      .WIDTH (CUM_W),
      .DEPTH (MAX_POINTS)
   ) u_cum_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_cumulative),
      .rd_addr (tbl_rd_addr),
      .rd_data (cum_rd_data)
   );

   icdf_ram #(
      .WIDTH (ENERGY_W),
      .DEPTH (MAX_POINTS)
   ) u_energy_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_energy),
      .rd_addr (tbl_rd_addr),
      .rd_data (energy_rd_data)
   );

   icdf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      // lower-bound halving step
      step = count_ff >> 1;
      mid  = first_ff + step;

      // points_in_use held to its legal range
      if ({21'b0, points_ff} < 32'(MIN_POINTS)) begin
         clamp_n = CNT_W'(MIN_POINTS);
      end else if ({21'b0, points_ff} > 32'(MAX_POINTS)) begin
         clamp_n = CNT_W'(MAX_POINTS);
      end else begin
         clamp_n = CNT_W'(points_ff);
      end

      num_raw = u_ff - c_lo_ff;

      state_in      = state_ff;
      points_in     = points_ff;
      n_in          = n_ff;
      u_in          = u_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      direct_in     = direct_ff;
      c_hi_in       = c_hi_ff;
      e_hi_in       = e_hi_ff;
      c_lo_in       = c_lo_ff;
      e_lo_in       = e_lo_ff;
      span_in       = span_ff;
      num_in        = num_ff;
      diff_in       = diff_ff;
      up_in         = up_ff;
      prod_in       = prod_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_lower_in  = rsp_lower_ff;
      tbl_rd_addr   = mid[ADDR_W-1:0];
      div_start     = 1'b0;

      if (csr_wr_en) begin
         points_in = csr_wr_data;
      end

      // output register empties on its transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_tuser == OP_SAMPLE)) begin
               u_in     = req_uniform;
               n_in     = clamp_n;
               first_in = '0;
               count_in = clamp_n;
               state_in = S_SRCH_ADDR;
            end
         end

         // issue the read of the middle entry, or leave once the range is empty
         S_SRCH_ADDR: begin
            tbl_rd_addr = mid[ADDR_W-1:0];
            if (count_ff == '0) begin
               state_in = S_RD_HI;
            end else begin
               state_in = S_SRCH_CMP;
            end
         end

         S_SRCH_CMP: begin
            if (cum_rd_data < u_ff) begin
               first_in = mid + 1'b1;
               count_in = count_ff - step - 1'b1;
            end else begin
               count_in = step;
            end
            state_in = S_SRCH_ADDR;
         end

         // pick the bracket; the end cases take only the energy at lo
         S_RD_HI: begin
            tbl_rd_addr = first_ff[ADDR_W-1:0];
            if (first_ff == '0) begin
               lo_in     = '0;
               direct_in = 1'b1;
            end else if (first_ff >= n_ff) begin
               lo_in     = ADDR_W'(n_ff - 1'b1);
               direct_in = 1'b1;
            end else begin
               lo_in     = ADDR_W'(first_ff - 1'b1);
               direct_in = 1'b0;
            end
            state_in = S_RD_LO;
         end

         S_RD_LO: begin
            tbl_rd_addr = lo_ff;
            c_hi_in     = cum_rd_data;
            e_hi_in     = energy_rd_data;
            state_in    = S_LATCH_LO;
         end

         S_LATCH_LO: begin
            tbl_rd_addr = lo_ff;
            c_lo_in     = cum_rd_data;
            e_lo_in     = energy_rd_data;
            state_in    = S_EVAL;
         end

         // zero fraction for end cases, empty or reversed span, draw at or below lo
         S_EVAL: begin
            span_in = c_hi_ff - c_lo_ff;
            num_in  = (num_raw > (c_hi_ff - c_lo_ff)) ? (c_hi_ff - c_lo_ff) : num_raw;
            up_in   = (e_hi_ff >= e_lo_ff);
            diff_in = (e_hi_ff >= e_lo_ff) ? (e_hi_ff - e_lo_ff) : (e_lo_ff - e_hi_ff);
            if (direct_ff || (c_hi_ff <= c_lo_ff) || (u_ff <= c_lo_ff)) begin
               result_in = e_lo_ff;
               state_in  = S_DONE;
            end else begin
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            prod_in  = PROD_W'(num_ff) * PROD_W'(diff_ff);
            state_in = S_DIV_GO;
         end

         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         // offset is truncated toward the lower entry's energy
         S_DIV_WAIT: begin
            if (div_done) begin
               result_in = up_ff ? (e_lo_ff + div_quotient) : (e_lo_ff - div_quotient);
               state_in  = S_DONE;
            end
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_energy_in = result_ff;
               rsp_lower_in  = INDEX_W'(lo_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         points_ff    <= POINTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      u_ff          <= u_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      lo_ff         <= lo_in;
      direct_ff     <= direct_in;
      c_hi_ff       <= c_hi_in;
      e_hi_ff       <= e_hi_in;
      c_lo_ff       <= c_lo_in;
      e_lo_ff       <= e_lo_in;
      span_ff       <= span_in;
      num_ff        <= num_in;
      diff_ff       <= diff_in;
      up_ff         <= up_in;
      prod_ff       <= prod_in;
      result_ff     <= result_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_lower_ff  <= rsp_lower_in;
   end

   // loads are taken whenever the sequencer is idle, even with a result pending
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_lower_ff, rsp_energy_ff};

endmodule

`default_nettype wire

@@ src/icdf_ram.sv @@
`default_nettype none

module icdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/icdf_divider.sv @@
`default_nettype none

// restoring divider, one quotient bit a cycle; the caller guarantees that
// the upper CUM_W bits of the dividend are below the divisor
module icdf_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [icdf_pkg::PROD_W-1:0]    dividend,
   input  wire logic [icdf_pkg::CUM_W-1:0]     divisor,
   output logic                                done,
   output logic      [icdf_pkg::ENERGY_W-1:0]  quotient
);

   import icdf_pkg::*;

   localparam int QUOT_W = ENERGY_W;
   localparam int CNT_W  = $clog2(QUOT_W + 1);

   logic [CUM_W-1:0]  rem_ff,  rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CUM_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              done_ff, done_in;

   logic [CUM_W:0]    shifted;
   logic [CUM_W+1:0]  trial;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[QUOT_W-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor_ff};
      fits    = ~trial[CUM_W+1];

      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;

      if (start) begin
         rem_in     = dividend[PROD_W-1:QUOT_W];
         quot_in    = dividend[QUOT_W-1:0];
         divisor_in = divisor;
         cnt_in     = CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? trial[CUM_W-1:0] : shifted[CUM_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire
